// ----- design/sfb_pkg.sv -----
// Package for the seam feather blend block: payload structs, register
// indexes, size constants and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package sfb_pkg;

  // Default width of the column and row counters.
  localparam int unsigned COORD_BITS_DEF = 12;

  // Configuration register geometry.
  localparam int unsigned REG_W     = 12;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = CFG_IDX_W'(1);

  // Pixel channel width and quotient width of the blend divider.
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned QUO_W   = 8;
  localparam int unsigned STEP_W  = $clog2(QUO_W);
  localparam int unsigned LANES   = 4;

  localparam logic [PIX_W-1:0] FULL_WEIGHT = PIX_W'(255);

  typedef struct packed {
    logic [PIX_W-1:0] left_c0;
    logic [PIX_W-1:0] left_c1;
    logic [PIX_W-1:0] left_c2;
    logic [PIX_W-1:0] right_c0;
    logic [PIX_W-1:0] right_c1;
    logic [PIX_W-1:0] right_c2;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_c0;
    logic [PIX_W-1:0] out_c1;
    logic [PIX_W-1:0] out_c2;
    logic [PIX_W-1:0] weight;
    logic             row_end;
    logic             region_end;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // take the input transaction and advance the counters
    logic load;     // form the numerators and arm the divider
    logic step;     // one restoring division step on all lanes
    logic emit;     // write the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last_step;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- design/sfb_ctrl.sv -----
// Controller state machine of the seam feather blend block.
// Depends on sfb_pkg for the command and status structs.
`default_nettype none

module sfb_ctrl
  import sfb_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.last_step) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Wait until the output register is empty or being drained.
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/sfb_datapath.sv -----
// Datapath of the seam feather blend block: position counters, numerator
// forming, four-lane restoring divider and the output register.
// Depends on sfb_pkg; driven by sfb_ctrl through cmd_t.
`default_nettype none

module sfb_datapath
  import sfb_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  input  wire in_t              in_data_i,
  input  wire logic [REG_W-1:0] width_i,
  input  wire logic [REG_W-1:0] height_i,
  input  wire logic             out_ready_i,
  output status_t               status_o,
  output logic                  out_valid_o,
  output out_t                  out_data_o
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned NUM_W = COORD_BITS + PIX_W;

  logic [CB-1:0] col_q, row_q;
  logic [CB-1:0] w_eff, h_eff, w_raw, h_raw;
  logic          last_col, last_row;

  in_t           px_q;
  logic [CB-1:0] colsat_q, weff_q;
  logic          lastcol_q, lastrow_q;

  logic [NUM_W-1:0] rem_q [LANES];
  logic [NUM_W-1:0] rem_d [LANES];
  logic [QUO_W-1:0] quo_q [LANES];
  logic [QUO_W-1:0] quo_d [LANES];
  logic [NUM_W-1:0] num   [LANES];
  logic [NUM_W-1:0] dsh_q;
  logic [STEP_W-1:0] step_q;

  logic [PIX_W-1:0] lft [3];
  logic [PIX_W-1:0] rgt [3];
  logic [CB-1:0]    wmc;
  logic             left_zero, right_zero;

  out_t out_q, out_d;
  logic out_valid_q;

  // Register values beyond the counter width are masked; zero acts as one.
  assign w_raw = CB'(width_i);
  assign h_raw = CB'(height_i);
  assign w_eff = (w_raw == '0) ? CB'(1) : w_raw;
  assign h_eff = (h_raw == '0) ? CB'(1) : h_raw;

  assign last_col = (col_q >= w_eff - CB'(1));
  assign last_row = (row_q >= h_eff - CB'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.capture) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + CB'(1);
      end else begin
        col_q <= col_q + CB'(1);
      end
    end
  end

  // Captured transaction; the column is clamped to the last column.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q      <= in_data_i;
      weff_q    <= w_eff;
      colsat_q  <= last_col ? (w_eff - CB'(1)) : col_q;
      lastcol_q <= last_col;
      lastrow_q <= last_row;
    end
  end

  assign lft[0] = px_q.left_c0;
  assign lft[1] = px_q.left_c1;
  assign lft[2] = px_q.left_c2;
  assign rgt[0] = px_q.right_c0;
  assign rgt[1] = px_q.right_c1;
  assign rgt[2] = px_q.right_c2;
  assign wmc    = weff_q - colsat_q;

  // Numerators stay below 256 * width, so they fit NUM_W bits.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = NUM_W'(rgt[k]) * NUM_W'(colsat_q) + NUM_W'(lft[k]) * NUM_W'(wmc);
    end
    num[3] = {colsat_q, {PIX_W{1'b0}}} - NUM_W'(colsat_q);
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (rem_q[k] >= dsh_q) begin
        rem_d[k] = rem_q[k] - dsh_q;
        quo_d[k] = {quo_q[k][QUO_W-2:0], 1'b1};
      end else begin
        rem_d[k] = rem_q[k];
        quo_d[k] = {quo_q[k][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < LANES; k++) begin
        rem_q[k] <= num[k];
        quo_q[k] <= '0;
      end
      dsh_q  <= NUM_W'({weff_q, {(QUO_W-1){1'b0}}});
      step_q <= '0;
    end else if (cmd_i.step) begin
      for (int k = 0; k < LANES; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
      dsh_q  <= dsh_q >> 1;
      step_q <= step_q + STEP_W'(1);
    end
  end

  assign left_zero  = ((px_q.left_c0 | px_q.left_c1 | px_q.left_c2) == '0);
  assign right_zero = ((px_q.right_c0 | px_q.right_c1 | px_q.right_c2) == '0);

  always_comb begin
    out_d.row_end    = lastcol_q;
    out_d.region_end = lastcol_q & lastrow_q;
    if (left_zero) begin
      out_d.out_c0 = px_q.right_c0;
      out_d.out_c1 = px_q.right_c1;
      out_d.out_c2 = px_q.right_c2;
      out_d.weight = FULL_WEIGHT;
    end else if (right_zero) begin
      out_d.out_c0 = px_q.left_c0;
      out_d.out_c1 = px_q.left_c1;
      out_d.out_c2 = px_q.left_c2;
      out_d.weight = '0;
    end else begin
      out_d.out_c0 = quo_q[0];
      out_d.out_c1 = quo_q[1];
      out_d.out_c2 = quo_q[2];
      out_d.weight = quo_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.last_step = (step_q == STEP_W'(QUO_W - 1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

endmodule

`default_nettype wire

// ----- design/seam_feather_blend_core.sv -----
// Top level of the seam feather blend block: configuration registers and the
// controller/datapath pair. Depends on sfb_pkg, sfb_ctrl and sfb_datapath.
`default_nettype none

// The block blends co-located pixel pairs from two overlapping views. The pairs
// arrive in row-major order over a region_width by region_height overlap. Each
// channel is a linear feather by column between the left and right pixel. The
// right-view weight (0 to 255) comes out with it, together with the row_end and
// region_end flags. A pixel pair whose left side is all zero passes the right
// pixel with weight 255. One whose right side is all zero passes the left pixel
// with weight 0. One transaction is in work at a time. Its steps, in order, are
// the accepting cycle, which captures the pixel pair and steps the counters,
// the load that forms the numerators, eight steps of the four-lane restoring
// divider (one quotient bit per step, all lanes in parallel) and the write of
// the result into the output register. The result is valid at the output in
// the cycle after that write, and the next pixel pair can be accepted from
// then on. A finished result waiting in the output register does not block
// acceptance of the next pixel pair. The write of that next pair does wait
// until the previous result is read or being read. Configuration writes are
// always ready and take effect at once.
// Write them only while no pixel is in work. A configuration write does not
// reset the counters.
module seam_feather_blend_core
  import sfb_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_t                      out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [REG_W-1:0]     cfg_data_i
);

  logic [REG_W-1:0] width_q, height_q;
  cmd_t             cmd;
  status_t          status;

  assign cfg_ready_o = 1'b1;

  // Writes to an index outside the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= REG_W'(1);
      height_q <= REG_W'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_REGION_WIDTH) begin
        width_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_REGION_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  sfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfb_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- bench/seam_feather_blend_checker.sv -----
// Scoreboard for the seam feather blend core: watches the pixel, result and
// register channels, predicts each blended pixel and compares it field by field.
// Depends on sfb_pkg.
`timescale 1ns / 100ps

module seam_feather_blend_checker
  import sfb_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_t                 out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  output int unsigned          fail_cnt_o,
  output int unsigned          pending_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  logic [REG_W-1:0]      region_w;
  logic [REG_W-1:0]      region_h;
  logic [COORD_BITS-1:0] col_pos;
  logic [COORD_BITS-1:0] row_pos;
  out_t                  expected_pixels [$];

  // A size of zero behaves as one.
  function automatic int unsigned region_size(input logic [REG_W-1:0] v);
    int unsigned s;
    s = v & ((1 << COORD_BITS) - 1);
    return (s == 0) ? 1 : s;
  endfunction

  function automatic logic [PIX_W-1:0] feather(input logic [PIX_W-1:0] l,
                                               input logic [PIX_W-1:0] r,
                                               input int unsigned col,
                                               input int unsigned w);
    return PIX_W'((r * col + l * (w - col)) / w);
  endfunction

  function automatic out_t blend_pixel(input in_t px);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    out_t res;
    w   = region_size(region_w);
    h   = region_size(region_h);
    col = col_pos;
    if (col > w - 1) begin
      col = w - 1;
    end
    if ((px.left_c0 | px.left_c1 | px.left_c2) == '0) begin
      res.out_c0 = px.right_c0;
      res.out_c1 = px.right_c1;
      res.out_c2 = px.right_c2;
      res.weight = FULL_WEIGHT;
    end else if ((px.right_c0 | px.right_c1 | px.right_c2) == '0) begin
      res.out_c0 = px.left_c0;
      res.out_c1 = px.left_c1;
      res.out_c2 = px.left_c2;
      res.weight = '0;
    end else begin
      res.out_c0 = feather(px.left_c0, px.right_c0, col, w);
      res.out_c1 = feather(px.left_c1, px.right_c1, col, w);
      res.out_c2 = feather(px.left_c2, px.right_c2, col, w);
      res.weight = PIX_W'((FULL_WEIGHT * col) / w);
    end
    res.row_end    = (col_pos >= w - 1);
    res.region_end = res.row_end && (row_pos >= h - 1);
    return res;
  endfunction

  task automatic note_failure(input string what);
    fail_cnt_o++;
    if (fail_cnt_o <= REPORT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    out_t want;
    out_t got;
    if (!rst_ni) begin
      region_w   <= REG_W'(1);
      region_h   <= REG_W'(1);
      col_pos    <= '0;
      row_pos    <= '0;
      fail_cnt_o = 0;
      pending_o  <= 0;
      expected_pixels.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (expected_pixels.size() == 0) begin
          note_failure($sformatf("result with none expected: %p", got));
        end else begin
          want = expected_pixels.pop_front();
          if (got.out_c0 !== want.out_c0 || got.out_c1 !== want.out_c1 ||
              got.out_c2 !== want.out_c2 || got.weight !== want.weight ||
              got.row_end !== want.row_end || got.region_end !== want.region_end) begin
            note_failure($sformatf("expected %p, got %p", want, got));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = blend_pixel(in_data_i);
        expected_pixels = {expected_pixels, want};
        if (want.row_end) begin
          col_pos <= '0;
          row_pos <= want.region_end ? '0 : row_pos + 1'b1;
        end else begin
          col_pos <= col_pos + 1'b1;
        end
      end
      // Writes to indexes beyond the register list are dropped.
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_REGION_WIDTH) begin
          region_w <= cfg_data_i;
        end else if (cfg_index_i == CFG_REGION_HEIGHT) begin
          region_h <= cfg_data_i;
        end
      end
      pending_o <= expected_pixels.size();
    end
  end

endmodule

// ----- bench/seam_feather_blend_core_tb.sv -----
// Testbench top for the seam feather blend core: clock, reset, pixel and
// register stimulus and the final verdict. Depends on sfb_pkg, the core and
// seam_feather_blend_checker.
`timescale 1ns / 100ps

module seam_feather_blend_core_tb
  import sfb_pkg::*;
();

  // Run length and safety net. The limit stays far above any correct run, even
  // with the receiver stalling most cycles.
  localparam int unsigned RANDOM_PIXELS = 1850;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned DRAIN_CYCLES  = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_REGION_HEIGHT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;
  localparam logic [REG_W-1:0]     SIZE_MAX         = '1;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data  = '0;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 71;
  int unsigned cycle_cnt     = 0;

  seam_feather_blend_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  seam_feather_blend_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  always #5 clk = ~clk;

  // The result side stalls at random; the percentage changes per phase.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hard stop in case the core hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Pick a channel value from the interesting corners of the 8-bit range.
  function automatic logic [PIX_W-1:0] corner_value();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h7F;
      3:       return 8'h80;
      4:       return 8'hFE;
      default: return 8'hFF;
    endcase
  endfunction

  // Most pixel pairs are fully random so that both sides are non-zero and the
  // feather path is exercised; the rest hit the pass-through cases and the
  // corner values.
  function automatic in_t random_pixel();
    in_t px;
    px = in_t'({$urandom, 16'($urandom)});
    case ($urandom_range(11))
      0: begin
        px.left_c0 = '0;
        px.left_c1 = '0;
        px.left_c2 = '0;
      end
      1: begin
        px.right_c0 = '0;
        px.right_c1 = '0;
        px.right_c2 = '0;
      end
      2: begin
        px = '0;
      end
      3, 4: begin
        px = {corner_value(), corner_value(), corner_value(),
              corner_value(), corner_value(), corner_value()};
      end
      default: begin
      end
    endcase
    return px;
  endfunction

  // Offer one pixel pair, idling first at random. Valid is only lowered when
  // the sender actually idles, so back-to-back transactions keep it high.
  task automatic send_pixel(input in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has come back, so the
  // core has nothing in work.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst;
    in_t         px;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes are one by one: every pixel ends a row and the region.
    // Cover both pixels zero, each side zero alone, and all-ones.
    send_pixel('0);
    send_pixel({24'h000000, 24'hFFFFFF});
    send_pixel({24'hFFFFFF, 24'h000000});
    send_pixel('1);
    send_pixel({24'h010101, 24'hFFFFFF});

    // A small 4 by 3 region walked completely with corner values, so that
    // row ends and the region end fall at known places.
    settle();
    write_reg(CFG_REGION_WIDTH, REG_W'(4));
    write_reg(CFG_REGION_HEIGHT, REG_W'(3));
    repeat (12) begin
      px = {corner_value(), corner_value(), corner_value(),
            corner_value(), corner_value(), corner_value()};
      send_pixel(px);
    end

    // Shrink the width in the middle of a row: the column counter is then past
    // the region, the blend position saturates and the row must still end.
    settle();
    write_reg(CFG_REGION_WIDTH, REG_W'(8));
    repeat (5) send_pixel(random_pixel());
    settle();
    write_reg(CFG_REGION_WIDTH, REG_W'(3));
    repeat (3) send_pixel(random_pixel());

    // Zero sizes act as one; writes to unused indexes must be ignored.
    settle();
    write_reg(CFG_REGION_WIDTH, '0);
    write_reg(CFG_REGION_HEIGHT, '0);
    write_reg(CFG_FIRST_UNUSED, REG_W'(5));
    write_reg(CFG_LAST_UNUSED, SIZE_MAX);
    repeat (2) send_pixel(random_pixel());

    // Largest region: weights stay small near the start of the row.
    settle();
    write_reg(CFG_REGION_WIDTH, SIZE_MAX);
    write_reg(CFG_REGION_HEIGHT, SIZE_MAX);
    send_pixel('1);
    send_pixel({24'h010203, 24'hFDFEFF});

    // Random part, in bursts between register updates. The idle pattern runs
    // through three stages: slow receiver, then slow sender, then full speed.
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      settle();
      if (sent < RANDOM_PIXELS / 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 71;
      end else if (sent < 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 71;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Mostly small regions so rows and regions wrap often; sometimes the
      // extremes or a wide region.
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(19))
          0:       write_reg(CFG_REGION_WIDTH, '0);
          1:       write_reg(CFG_REGION_WIDTH, SIZE_MAX);
          2:       write_reg(CFG_REGION_WIDTH, REG_W'($urandom_range(17, 4094)));
          default: write_reg(CFG_REGION_WIDTH, REG_W'($urandom_range(1, 16)));
        endcase
      end
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0:       write_reg(CFG_REGION_HEIGHT, '0);
          1:       write_reg(CFG_REGION_HEIGHT, SIZE_MAX);
          default: write_reg(CFG_REGION_HEIGHT, REG_W'($urandom_range(1, 6)));
        endcase
      end
      if ($urandom_range(7) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                  REG_W'($urandom));
      end
      burst = $urandom_range(10, 80);
      repeat (burst) send_pixel(random_pixel());
      sent += burst;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- seam_feather_blend_core.f -----
design/sfb_pkg.sv
design/sfb_ctrl.sv
design/sfb_datapath.sv
design/seam_feather_blend_core.sv
bench/seam_feather_blend_checker.sv
bench/seam_feather_blend_core_tb.sv
